@@ hdl/swms_pkg.sv @@
// ----------------------------------------------------------------------------
// swms_pkg
// shared constants, types and helpers for the sliding window mean/deviation unit
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int WINDOW_DAYS   = 14;
    localparam int FEATURE_COUNT = 5;
    localparam int SAMPLE_BITS   = 24;
    localparam int NUM_FIELDS    = 5;
    localparam int FIELD_BITS    = 24;
    localparam int SUM_BITS      = 28;
    localparam int SQ_BITS       = 52;
    localparam int SLOT_BITS     = 4;
    localparam int FEAT_BITS     = 3;
    localparam int ROOT_BITS     = 32;
    localparam int RAD_BITS      = 64;
    localparam int ROW_BITS      = FEATURE_COUNT * SAMPLE_BITS;
    localparam int IN_BITS       = NUM_FIELDS * FIELD_BITS;
    localparam int OUT_BITS      = 2 * NUM_FIELDS * FIELD_BITS;

    // reciprocal of the window length, exact for any 32-bit dividend
    localparam int DIV_SHIFT = 36;
    localparam int PROD_BITS = ROOT_BITS + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV_MAGIC =
        DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_DAYS) - 64'd1) / 64'(WINDOW_DAYS));

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [SQ_BITS-1:0]     sq_t;
    typedef logic [SLOT_BITS-1:0]   slot_t;
    typedef logic [FEAT_BITS-1:0]   feat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_PREP,
        ST_CALC,
        ST_ROOT,
        ST_STORE,
        ST_OUT
    } state_t;

    // start/done between control and the root unit
    typedef struct packed {
        logic                start;
        logic [RAD_BITS-1:0] radicand;
    } root_req_t;

    typedef struct packed {
        logic                  done;
        logic [ROOT_BITS-1:0]  root;
    } root_rsp_t;

    // floor(v / WINDOW_DAYS) by multiplying with the rounded-up reciprocal
    function automatic logic [FIELD_BITS-1:0] div_window(input logic [ROOT_BITS-1:0] v);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(v) * PROD_BITS'(DIV_MAGIC);
        return prod[DIV_SHIFT +: FIELD_BITS];
    endfunction

endpackage

@@ hdl/swms_isqrt.sv @@
// ----------------------------------------------------------------------------
// swms_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module swms_isqrt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swms_pkg::root_req_t  req,
    output swms_pkg::root_rsp_t  rsp
);

    localparam int RB = swms_pkg::RAD_BITS;
    localparam int QB = swms_pkg::ROOT_BITS;

    logic [RB-1:0]   rad_reg;
    logic [QB-1:0]   acc_reg;
    logic [QB-1:0]   root_reg;
    logic [5:0]      step_reg, step_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [QB+1:0]   acc_sh;
    logic [QB+1:0]   try_val;
    logic [QB+1:0]   acc_diff;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            step_next = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(QB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // bring down two radicand bits, try appending a one
    always_comb
    begin
        acc_sh   = {acc_reg, rad_reg[RB-1 -: 2]};
        try_val  = {root_reg, 2'b01};
        acc_diff = acc_sh - try_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // remainder stays below 2^32 until the final step, whose remainder is unused
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            acc_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RB-3:0], 2'b00};
            if (acc_sh >= try_val)
            begin
                acc_reg  <= acc_diff[QB-1:0];
                root_reg <= {root_reg[QB-2:0], 1'b1};
            end
            else
            begin
                acc_reg  <= acc_sh[QB-1:0];
                root_reg <= {root_reg[QB-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

@@ hdl/swms_ctrl.sv @@
// ----------------------------------------------------------------------------
// swms_ctrl
// ring memory, running sums and per-feature sequencing
// ----------------------------------------------------------------------------
module swms_ctrl
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [swms_pkg::IN_BITS-1:0]    in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [swms_pkg::OUT_BITS-1:0]   out_data,
    output swms_pkg::root_req_t             root_req,
    input  swms_pkg::root_rsp_t             root_rsp
);

    localparam int FB = swms_pkg::FIELD_BITS;
    localparam int NF = swms_pkg::NUM_FIELDS;

    swms_pkg::state_t state_reg, state_next;

    // ring memory: one row holds every feature of a record
    logic [swms_pkg::ROW_BITS-1:0] ring_mem [swms_pkg::WINDOW_DAYS];
    logic [swms_pkg::ROW_BITS-1:0] old_row_reg;
    logic [swms_pkg::ROW_BITS-1:0] new_row_reg;

    swms_pkg::sum_t sum_reg [swms_pkg::FEATURE_COUNT];
    swms_pkg::sq_t  sq_reg  [swms_pkg::FEATURE_COUNT];

    swms_pkg::slot_t slot_reg;
    swms_pkg::slot_t fill_reg;
    swms_pkg::feat_t feat_reg;
    logic            full_reg;

    logic [swms_pkg::OUT_BITS-1:0] res_reg;
    logic [63:0]                   nq_reg, ss_reg;

    logic in_fire, out_fire, last_feat;
    swms_pkg::sample_t x_cur, old_cur;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign last_feat = (feat_reg == swms_pkg::feat_t'(swms_pkg::FEATURE_COUNT - 1));

    always_comb
    begin
        x_cur   = new_row_reg[feat_reg*swms_pkg::SAMPLE_BITS +: swms_pkg::SAMPLE_BITS];
        old_cur = old_row_reg[feat_reg*swms_pkg::SAMPLE_BITS +: swms_pkg::SAMPLE_BITS];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swms_pkg::ST_IDLE:   if (in_fire) state_next = swms_pkg::ST_READ;
            swms_pkg::ST_READ:   state_next = swms_pkg::ST_UPDATE;
            swms_pkg::ST_UPDATE:
            begin
                if (last_feat)
                    state_next = (fill_reg == swms_pkg::slot_t'(swms_pkg::WINDOW_DAYS - 1)
                                  || full_reg) ? swms_pkg::ST_PREP : swms_pkg::ST_IDLE;
            end
            swms_pkg::ST_PREP:   state_next = swms_pkg::ST_CALC;
            swms_pkg::ST_CALC:   state_next = swms_pkg::ST_ROOT;
            swms_pkg::ST_ROOT:   if (root_rsp.done) state_next = swms_pkg::ST_STORE;
            swms_pkg::ST_STORE:  state_next = last_feat ? swms_pkg::ST_OUT : swms_pkg::ST_PREP;
            swms_pkg::ST_OUT:    if (out_fire) state_next = swms_pkg::ST_IDLE;
            default:             state_next = swms_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready          = (state_reg == swms_pkg::ST_IDLE);
        out_valid         = (state_reg == swms_pkg::ST_OUT);
        root_req.start    = (state_reg == swms_pkg::ST_CALC);
        root_req.radicand = (nq_reg >= ss_reg) ? (nq_reg - ss_reg) : 64'd0;
    end

    assign out_data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swms_pkg::ST_IDLE;
            slot_reg  <= '0;
            fill_reg  <= '0;
            full_reg  <= 1'b0;
            feat_reg  <= '0;
            for (int i = 0; i < swms_pkg::FEATURE_COUNT; i++)
            begin
                sum_reg[i] <= '0;
                sq_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == swms_pkg::ST_READ)
                feat_reg <= '0;
            if (state_reg == swms_pkg::ST_UPDATE)
            begin
                sum_reg[feat_reg] <= sum_reg[feat_reg]
                    - (full_reg ? swms_pkg::sum_t'(old_cur) : '0)
                    + swms_pkg::sum_t'(x_cur);
                sq_reg[feat_reg] <= sq_reg[feat_reg]
                    - (full_reg ? swms_pkg::sq_t'(old_cur) * swms_pkg::sq_t'(old_cur) : '0)
                    + swms_pkg::sq_t'(x_cur) * swms_pkg::sq_t'(x_cur);
                if (last_feat)
                begin
                    feat_reg <= '0;
                    slot_reg <= (slot_reg == swms_pkg::slot_t'(swms_pkg::WINDOW_DAYS - 1))
                                ? '0 : slot_reg + 1'b1;
                    if (!full_reg)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg == swms_pkg::slot_t'(swms_pkg::WINDOW_DAYS - 1))
                            full_reg <= 1'b1;
                    end
                end
                else
                    feat_reg <= feat_reg + 1'b1;
            end
            if (state_reg == swms_pkg::ST_STORE)
                feat_reg <= last_feat ? '0 : feat_reg + 1'b1;
        end
    end

    // memory: read old row on accept, write new row in the following ST_READ cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            old_row_reg <= ring_mem[slot_reg];
            for (int i = 0; i < swms_pkg::FEATURE_COUNT; i++)
                new_row_reg[i*swms_pkg::SAMPLE_BITS +: swms_pkg::SAMPLE_BITS]
                    <= in_data[i*FB +: swms_pkg::SAMPLE_BITS];
        end
        if (state_reg == swms_pkg::ST_READ)
            ring_mem[slot_reg] <= new_row_reg;
    end

    // per-feature products; both fit in 56 bits, so no radicand bits drop
    always_ff @(posedge clk)
    begin
        if (state_reg == swms_pkg::ST_UPDATE && last_feat)
            res_reg <= '0;
        if (state_reg == swms_pkg::ST_PREP)
        begin
            nq_reg <= 64'(sq_reg[feat_reg]) * 64'(swms_pkg::WINDOW_DAYS);
            ss_reg <= 64'(sum_reg[feat_reg]) * 64'(sum_reg[feat_reg]);
        end
        if (state_reg == swms_pkg::ST_STORE)
        begin
            res_reg[feat_reg*FB +: FB] <=
                swms_pkg::div_window(32'(sum_reg[feat_reg]));
            res_reg[(NF+feat_reg)*FB +: FB] <= swms_pkg::div_window(root_rsp.root);
        end
    end

endmodule

@@ hdl/sliding_window_mean_stddev_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev_unit
// moving-window mean and population deviation over five-sample records
// ----------------------------------------------------------------------------
// sequencing: an accepted record is stored first; once the window is full the
//   results follow feature by feature before the output transaction is offered
// flow: a new record is accepted only after the previous one is finished,
//   paced by the shared bit-serial square root unit (32 steps per feature)
// reset: asynchronous active-low clears sums, ring pointer and fill count
module sliding_window_mean_stddev_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // feature_0 .. feature_4
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [239:0] m_axis_tdata   // mean_0 .. mean_4, spread_0 .. spread_4
);

    swms_pkg::root_req_t root_req;
    swms_pkg::root_rsp_t root_rsp;

    swms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .root_req  (root_req),
        .root_rsp  (root_rsp)
    );

    swms_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_root_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        root_req.start |=> !root_rsp.done)
        else $error("root finished too early");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the moving-window mean and deviation unit: records
// are streamed in with random gaps, a local window model predicts each result
// and a scoreboard compares every output transaction field by field
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WINDOW_DAYS   = swms_pkg::WINDOW_DAYS;
    localparam int FEATURE_COUNT = swms_pkg::FEATURE_COUNT;
    localparam int SAMPLE_BITS   = swms_pkg::SAMPLE_BITS;
    localparam int NUM_FIELDS    = swms_pkg::NUM_FIELDS;
    localparam int FIELD_BITS    = swms_pkg::FIELD_BITS;
    localparam int SUM_BITS      = swms_pkg::SUM_BITS;
    localparam int SQ_BITS       = swms_pkg::SQ_BITS;

    localparam int NUM_RECORDS = 1750;

    typedef logic [FIELD_BITS-1:0] field_t;

    class window_scoreboard;
        field_t       ring [WINDOW_DAYS][NUM_FIELDS];
        int           slot;
        int           held;
        logic [63:0]  total [NUM_FIELDS];
        logic [63:0]  sq_total [NUM_FIELDS];
        logic [239:0] pending [$];
        int           errors;
        int           results_seen;

        function new();
            slot = 0;
            held = 0;
            errors = 0;
            results_seen = 0;
            for (int f = 0; f < NUM_FIELDS; f++)
            begin
                total[f] = 0;
                sq_total[f] = 0;
            end
        endfunction

        function automatic logic [63:0] floor_root(input logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // note an accepted record and queue its result once the window is full
        function void note_record(input logic [119:0] rec);
            logic [63:0]  x;
            logic [63:0]  old;
            logic [63:0]  nq;
            logic [63:0]  s2;
            logic [239:0] res;
            bit           full_before;
            full_before = (held >= WINDOW_DAYS);
            for (int f = 0; f < FEATURE_COUNT; f++)
            begin
                x = 64'(rec[f*FIELD_BITS +: SAMPLE_BITS]);
                if (full_before)
                begin
                    old = 64'(ring[slot][f]);
                    total[f] = (total[f] - old) & ((64'd1 << SUM_BITS) - 1);
                    sq_total[f] = (sq_total[f] - old * old) & ((64'd1 << SQ_BITS) - 1);
                end
                ring[slot][f] = field_t'(x);
                total[f] = (total[f] + x) & ((64'd1 << SUM_BITS) - 1);
                sq_total[f] = (sq_total[f] + x * x) & ((64'd1 << SQ_BITS) - 1);
            end
            slot = (slot + 1) % WINDOW_DAYS;
            if (held < WINDOW_DAYS)
                held++;
            if (held < WINDOW_DAYS)
                return;
            res = '0;
            for (int f = 0; f < FEATURE_COUNT; f++)
            begin
                nq = sq_total[f] * 64'(WINDOW_DAYS);
                s2 = total[f] * total[f];
                res[f*FIELD_BITS +: FIELD_BITS] = field_t'(total[f] / WINDOW_DAYS);
                res[(NUM_FIELDS+f)*FIELD_BITS +: FIELD_BITS] =
                    field_t'(floor_root((nq >= s2) ? nq - s2 : 64'd0) / WINDOW_DAYS);
            end
            pending.push_back(res);
        endfunction

        function void check_result(input logic [239:0] got);
            logic [239:0] want;
            results_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 2 * NUM_FIELDS; k++)
                if (got[k*FIELD_BITS +: FIELD_BITS] !== want[k*FIELD_BITS +: FIELD_BITS])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d field %0d: expected %h, got %h", results_seen,
                                 k, want[k*FIELD_BITS +: FIELD_BITS],
                                 got[k*FIELD_BITS +: FIELD_BITS]);
                end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;  // feature_0 .. feature_4
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [239:0] m_axis_tdata;  // mean_0 .. mean_4, spread_0 .. spread_4

    window_scoreboard board;
    bit               calm;
    int               records_sent;

    sliding_window_mean_stddev_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [119:0] random_record(input int style);
        logic [119:0] r;
        for (int f = 0; f < NUM_FIELDS; f++)
            case (style)
                0: r[f*FIELD_BITS +: FIELD_BITS] = field_t'($urandom);
                1: r[f*FIELD_BITS +: FIELD_BITS] =
                    field_t'($urandom_range(16777215, 16776000));
                2: r[f*FIELD_BITS +: FIELD_BITS] = field_t'($urandom_range(300, 0));
                default: r[f*FIELD_BITS +: FIELD_BITS] =
                    ($urandom_range(1, 0) != 0) ? 24'hFFFFFF : 24'h000000;
            endcase
        return r;
    endfunction

    // one record transaction, with an optional random gap first
    task automatic send_record(input logic [119:0] rec);
        if (!calm && $urandom_range(3, 0) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rec;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_record(rec);
        records_sent++;
    endtask

    // output side: random stall bursts, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(4, 0) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(11, 1)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        board = new();
        calm = 1'b0;
        records_sent = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill with alternating all-zero/all-max records, then all-max and walking bits
        for (int i = 0; i < WINDOW_DAYS; i++)
            send_record((i % 2) ? {120{1'b1}} : {120{1'b0}});
        for (int i = 0; i < 4; i++)
            send_record({120{1'b1}});
        for (int i = 0; i < 6; i++)
            send_record({5{24'h1 << (i * 4)}});

        for (int i = 0; i < NUM_RECORDS; i++)
        begin
            if (i > NUM_RECORDS - 150)
                calm = 1'b1;
            send_record(random_record(($urandom_range(6, 0) > 3) ?
                                      int'($urandom_range(3, 1)) : 0));
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("%0d records sent, %0d results checked, window length %0d",
                 records_sent, board.results_seen, WINDOW_DAYS);
        if (board.errors == 0)
            $display("sliding_window_mean_stddev_unit: match");
        else
            $display("sliding_window_mean_stddev_unit: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("sliding_window_mean_stddev_unit: mismatch");
        $finish;
    end

endmodule
